FILE: hdl/hwt_pkg.sv
// Shared types, constants and helpers for the 2x2 RGB Haar wavelet block.
// Used by every module under hdl; has no dependencies of its own.
package hwt_pkg;

  // Frame size limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MAX_W_EVEN = (MAX_WIDTH / 2) * 2;
  localparam int MAX_H_EVEN = (MAX_HEIGHT / 2) * 2;

  // Field and datapath widths
  localparam int DIM_W  = 11;                          // size register width
  localparam int WID_W  = $clog2(MAX_W_EVEN + 1);      // effective width
  localparam int HEI_W  = $clog2(MAX_H_EVEN + 1);      // effective height
  localparam int SZ_W   = (DIM_W > WID_W) ? ((DIM_W > HEI_W) ? DIM_W : HEI_W)
                                          : ((WID_W > HEI_W) ? WID_W : HEI_W);
  localparam int COL_W  = $clog2(MAX_W_EVEN / 2);      // block column counter
  localparam int ROW_W  = $clog2(MAX_H_EVEN / 2);      // block row counter
  localparam int IDX_W  = 20;
  localparam int CH_W   = 8;
  localparam int NUM_CH = 3;
  localparam int NUM_BANDS = 4;
  localparam int PIX_W  = CH_W * NUM_CH;
  localparam int BAND_W = 2;

  localparam logic [CH_W-1:0]  DIFF_OFFSET = 8'd128;
  localparam logic [DIM_W-1:0] SIZE_RESET  = 11'd512;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

  // Band codes
  localparam logic [BAND_W-1:0] BAND_AVG  = 2'd0;
  localparam logic [BAND_W-1:0] BAND_TB   = 2'd1;
  localparam logic [BAND_W-1:0] BAND_LR   = 2'd2;
  localparam logic [BAND_W-1:0] BAND_DIAG = 2'd3;

  // Channel payloads
  typedef struct packed {
    logic [PIX_W-1:0] top_left_rgb;
    logic [PIX_W-1:0] top_right_rgb;
    logic [PIX_W-1:0] bottom_left_rgb;
    logic [PIX_W-1:0] bottom_right_rgb;
  } in_item_t;

  typedef struct packed {
    logic [BAND_W-1:0] band;
    logic [IDX_W-1:0]  pixel_index;
    logic [CH_W-1:0]   red;
    logic [CH_W-1:0]   green;
    logic [CH_W-1:0]   blue;
    logic              last_of_block;
    logic              end_of_frame;
  } out_item_t;

  // Per-lane coefficients, one per band
  typedef logic [NUM_BANDS-1:0][CH_W-1:0] lane_coef_t;

  // Addressing for one block
  typedef struct packed {
    logic [IDX_W-1:0] base;    // top-left quadrant index
    logic [IDX_W-1:0] off_h;   // half width
    logic [IDX_W-1:0] off_v;   // half height times width
    logic             eof;
  } addr_info_t;

  // One block in flight
  typedef struct packed {
    logic [NUM_BANDS-1:0][NUM_CH-1:0][CH_W-1:0] coef;
    addr_info_t                                 addr;
  } block_t;

  // Effective size: clear bit zero, cap at the even maximum, floor at two
  function automatic logic [SZ_W-1:0] eff_size(input logic [DIM_W-1:0] r,
                                               input logic [SZ_W-1:0]  cap);
    logic [SZ_W-1:0] v;
    v = SZ_W'(r & ~DIM_W'(1));
    if (v > cap) v = cap;
    if (v < SZ_W'(2)) v = SZ_W'(2);
    return v;
  endfunction

endpackage

FILE: hdl/hwt_lane.sv
// One colour channel lane: the four Haar coefficients of a 2x2 block.
// Depends on hwt_pkg.
module hwt_lane
  import hwt_pkg::*;
(
  input  logic [CH_W-1:0] a,
  input  logic [CH_W-1:0] b,
  input  logic [CH_W-1:0] c,
  input  logic [CH_W-1:0] d,
  output lane_coef_t      coef
);

  // Signed difference over four, truncating toward zero, plus offset
  function automatic logic [CH_W-1:0] diff_coef(input logic signed [CH_W+2:0] s);
    logic signed [CH_W+2:0] q;
    q = (s + (s[CH_W+2] ? (CH_W+3)'(3) : (CH_W+3)'(0))) >>> 2;
    return q[CH_W-1:0] + DIFF_OFFSET;
  endfunction

  logic [CH_W+1:0]        sum_all;
  logic signed [CH_W+2:0] d_tb;
  logic signed [CH_W+2:0] d_lr;
  logic signed [CH_W+2:0] d_dg;

  // Sums and differences
  always_comb begin
    sum_all = (CH_W+2)'(a) + (CH_W+2)'(b) + (CH_W+2)'(c) + (CH_W+2)'(d);
    d_tb = $signed((CH_W+3)'(a) + (CH_W+3)'(b) - (CH_W+3)'(c) - (CH_W+3)'(d));
    d_lr = $signed((CH_W+3)'(a) - (CH_W+3)'(b) + (CH_W+3)'(c) - (CH_W+3)'(d));
    d_dg = $signed((CH_W+3)'(a) - (CH_W+3)'(b) - (CH_W+3)'(c) + (CH_W+3)'(d));
  end

  // Coefficients per band
  always_comb begin
    coef[BAND_AVG]  = sum_all[CH_W+1:2];
    coef[BAND_TB]   = diff_coef(d_tb);
    coef[BAND_LR]   = diff_coef(d_lr);
    coef[BAND_DIAG] = diff_coef(d_dg);
  end

endmodule

FILE: hdl/hwt_addr.sv
// Size registers, block position counters and quadrant addressing.
// Depends on hwt_pkg.
module hwt_addr
  import hwt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data,
  input  logic                 take,
  output addr_info_t           info
);

  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;
  logic [COL_W-1:0] block_column;
  logic [COL_W-1:0] block_column_next;
  logic [ROW_W-1:0] block_row;
  logic [ROW_W-1:0] block_row_next;

  logic [WID_W-1:0] w;
  logic [WID_W-1:0] hw;
  logic [HEI_W-1:0] h;
  logic [HEI_W-1:0] hh;
  logic [WID_W-1:0] col_inc;
  logic [HEI_W-1:0] row_inc;
  logic             col_wrap;
  logic             row_wrap;
  logic [ROW_W+WID_W-1:0] row_prod;
  logic [HEI_W+WID_W-1:0] vert_prod;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= SIZE_RESET;
      image_height <= SIZE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective sizes and wrap tests
  always_comb begin
    w        = WID_W'(eff_size(image_width, SZ_W'(MAX_W_EVEN)));
    h        = HEI_W'(eff_size(image_height, SZ_W'(MAX_H_EVEN)));
    hw       = w >> 1;
    hh       = h >> 1;
    col_inc  = WID_W'(block_column) + WID_W'(1);
    row_inc  = HEI_W'(block_row) + HEI_W'(1);
    col_wrap = (col_inc >= hw);
    row_wrap = (row_inc >= hh);
  end

  // Counter advance
  always_comb begin
    block_column_next = block_column;
    block_row_next    = block_row;
    if (take) begin
      if (col_wrap) begin
        block_column_next = '0;
        block_row_next    = row_wrap ? '0 : ROW_W'(row_inc);
      end else begin
        block_column_next = COL_W'(col_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_column <= '0;
      block_row    <= '0;
    end else begin
      block_column <= block_column_next;
      block_row    <= block_row_next;
    end
  end

  // Quadrant addressing, indexes kept modulo the index width
  always_comb begin
    row_prod   = block_row * w;
    vert_prod  = hh * w;
    info.base  = IDX_W'(row_prod) + IDX_W'(block_column);
    info.off_h = IDX_W'(hw);
    info.off_v = IDX_W'(vert_prod);
    info.eof   = col_wrap && row_wrap;
  end

endmodule

FILE: hdl/hwt_merge.sv
// Merging stage: holds a block from the lanes and sends its four bands
// in order. Two block registers let the next block in while one drains.
// Depends on hwt_pkg.
module hwt_merge
  import hwt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  block_t    blk_in,
  output logic      take,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  logic              hold_valid;
  logic              hold_valid_next;
  block_t            hold;
  logic              send_valid;
  logic              send_valid_next;
  block_t            send;
  logic [BAND_W-1:0] band;
  logic [BAND_W-1:0] band_next;
  logic              send_done;
  logic              move;

  // Handshake control
  always_comb begin
    send_done = send_valid && out_ready && (band == BAND_DIAG);
    move      = hold_valid && (!send_valid || send_done);
    in_ready  = !hold_valid || move;
    take      = in_valid && in_ready;
  end

  // Next-state for valid flags and band counter
  always_comb begin
    hold_valid_next = hold_valid;
    if (take) hold_valid_next = 1'b1;
    else if (move) hold_valid_next = 1'b0;

    send_valid_next = send_valid;
    if (move) send_valid_next = 1'b1;
    else if (send_done) send_valid_next = 1'b0;

    band_next = band;
    if (move) band_next = BAND_AVG;
    else if (send_valid && out_ready) band_next = band + BAND_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      send_valid <= 1'b0;
      band       <= BAND_AVG;
    end else begin
      hold_valid <= hold_valid_next;
      send_valid <= send_valid_next;
      band       <= band_next;
    end
  end

  // Block payload registers
  always_ff @(posedge clk) begin
    if (take) hold <= blk_in;
    if (move) send <= hold;
  end

  // Result selection
  always_comb begin
    out_valid              = send_valid;
    out_item.band          = band;
    out_item.pixel_index   = send.addr.base
                           + (band[0] ? send.addr.off_h : '0)
                           + (band[1] ? send.addr.off_v : '0);
    out_item.red           = send.coef[band][0];
    out_item.green         = send.coef[band][1];
    out_item.blue          = send.coef[band][2];
    out_item.last_of_block = (band == BAND_DIAG);
    out_item.end_of_frame  = (band == BAND_DIAG) && send.addr.eof;
  end

endmodule

FILE: hdl/haar_wavelet_2x2_rgb.sv
// Top level of the single-level 2x2 RGB Haar wavelet block.
// Depends on hwt_pkg, hwt_lane, hwt_addr and hwt_merge.
//
// Usage:
//   in_valid/in_ready/in_item carry one 2x2 RGB pixel block per transfer,
//   blocks in raster order. out_valid/out_ready/out_item carry four
//   results per block: average, top-bottom, left-right and diagonal
//   bands, each with its destination index in the quadrant layout.
//   cfg_write/cfg_index/cfg_data write image_width (index 0) and
//   image_height (index 1); write them only while the block is idle.
// Path: a block taken at the input is registered in the hold register and
//   then moved to the send register, which drives out_valid; its first
//   result transfers when the output side is free.
// Output port: the single result port sends four bands per block and sets
//   the pace; a hold register takes the next block while one drains, and
//   three channel lanes compute a block's coefficients combinationally.
// Reset: rst (synchronous) clears the block counters, empties both block
//   registers and sets both sizes to 512.
// Stall: while out_ready is low the current result holds; one further
//   block is taken and held, after which in_ready drops.
module haar_wavelet_2x2_rgb
  import hwt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_item,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  lane_coef_t lane_coef [NUM_CH];
  addr_info_t info;
  block_t     blk;
  logic       take;

  // Channel lanes
  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
    hwt_lane u_lane (
      .a    (in_item.top_left_rgb[ch*CH_W +: CH_W]),
      .b    (in_item.top_right_rgb[ch*CH_W +: CH_W]),
      .c    (in_item.bottom_left_rgb[ch*CH_W +: CH_W]),
      .d    (in_item.bottom_right_rgb[ch*CH_W +: CH_W]),
      .coef (lane_coef[ch])
    );
  end

  // Counters and addressing
  hwt_addr u_addr (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .take      (take),
    .info      (info)
  );

  // Gather lane results into one block
  always_comb begin
    for (int k = 0; k < NUM_BANDS; k++) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        blk.coef[k][ch] = lane_coef[ch][k];
      end
    end
    blk.addr = info;
  end

  // Merge and send
  hwt_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .blk_in    (blk),
    .take      (take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

FILE: verif/haar_wavelet_2x2_rgb_test.sv
// Self-checking testbench for haar_wavelet_2x2_rgb: a directed table of 2x2 blocks, then
// random frames of random size, every band result checked against a Haar predictor.
// Depends on hwt_pkg and the haar_wavelet_2x2_rgb RTL.
module haar_wavelet_2x2_rgb_test;
  import hwt_pkg::*;

  localparam int RANDOM_BLOCKS = 460;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 8;
  localparam int MAX_REPORTS   = 10;
  localparam int NUM_DIRECTED  = 24;

  typedef logic [PIX_W-1:0] pixel_t;
  typedef logic [0:NUM_BANDS-1][PIX_W-1:0] band_rgb_t;

  // One directed row: optional size write, the block, optional typed coefficients
  typedef struct packed {
    logic             new_size;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    in_item_t         blk;
    logic             typed;
    band_rgb_t        coefs;
  } dir_row_t;

  localparam logic [BAND_W-1:0] BAND_ORDER [NUM_BANDS] = '{BAND_AVG, BAND_TB, BAND_LR, BAND_DIAG};

  // Coefficients per band, in band order, packed as the pixels are (blue, green, red)
  localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
    // reset sizes: flat black, flat white, then one corner lit at a time
    '{1'b0, 11'd0, 11'd0, '{24'h000000, 24'h000000, 24'h000000, 24'h000000}, 1'b1,
      {24'h000000, 24'h808080, 24'h808080, 24'h808080}},
    '{1'b0, 11'd0, 11'd0, '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF}, 1'b1,
      {24'hFFFFFF, 24'h808080, 24'h808080, 24'h808080}},
    '{1'b0, 11'd0, 11'd0, '{24'hFFFFFF, 24'h000000, 24'h000000, 24'h000000}, 1'b1,
      {24'h3F3F3F, 24'hBFBFBF, 24'hBFBFBF, 24'hBFBFBF}},
    '{1'b0, 11'd0, 11'd0, '{24'h000000, 24'hFFFFFF, 24'h000000, 24'h000000}, 1'b1,
      {24'h3F3F3F, 24'hBFBFBF, 24'h414141, 24'h414141}},
    '{1'b0, 11'd0, 11'd0, '{24'h000000, 24'h000000, 24'hFFFFFF, 24'h000000}, 1'b1,
      {24'h3F3F3F, 24'h414141, 24'hBFBFBF, 24'h414141}},
    '{1'b0, 11'd0, 11'd0, '{24'h000000, 24'h000000, 24'h000000, 24'hFFFFFF}, 1'b1,
      {24'h3F3F3F, 24'h414141, 24'h414141, 24'hBFBFBF}},
    // sizes below two round up to a 2x2 image, counters beyond the new limit
    '{1'b1, 11'd0, 11'd1, '{24'hFFFFFF, 24'hFFFFFF, 24'h000000, 24'h000000}, 1'b1,
      {24'h7F7F7F, 24'hFFFFFF, 24'h808080, 24'h808080}},
    '{1'b0, 11'd0, 11'd0, '{24'h000000, 24'h000000, 24'hFFFFFF, 24'hFFFFFF}, 1'b1,
      {24'h7F7F7F, 24'h010101, 24'h808080, 24'h808080}},
    '{1'b0, 11'd0, 11'd0, '{24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h000000}, 1'b1,
      {24'h7F7F7F, 24'h808080, 24'hFFFFFF, 24'h808080}},
    '{1'b0, 11'd0, 11'd0, '{24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF}, 1'b1,
      {24'h7F7F7F, 24'h808080, 24'h010101, 24'h808080}},
    '{1'b0, 11'd0, 11'd0, '{24'hFFFFFF, 24'h000000, 24'h000000, 24'hFFFFFF}, 1'b1,
      {24'h7F7F7F, 24'h808080, 24'h808080, 24'hFFFFFF}},
    '{1'b0, 11'd0, 11'd0, '{24'h000000, 24'hFFFFFF, 24'hFFFFFF, 24'h000000}, 1'b1,
      {24'h7F7F7F, 24'h808080, 24'h808080, 24'h010101}},
    // truncation toward zero on small negative differences
    '{1'b0, 11'd0, 11'd0, '{24'h000000, 24'h030303, 24'h000000, 24'h000000}, 1'b1,
      {24'h000000, 24'h808080, 24'h808080, 24'h808080}},
    '{1'b0, 11'd0, 11'd0, '{24'h000000, 24'h000000, 24'h070707, 24'h000000}, 1'b1,
      {24'h010101, 24'h7F7F7F, 24'h818181, 24'h7F7F7F}},
    // oversize registers saturate to the maximum
    '{1'b1, 11'd2047, 11'd2047, '{24'h123456, 24'hABCDEF, 24'h00FF80, 24'h7F0180}, 1'b0, '0},
    '{1'b0, 11'd0, 11'd0, '{24'hFF0000, 24'h00FF00, 24'h0000FF, 24'h808080}, 1'b0, '0},
    // 6x4 image: column and row wrap, end of frame
    '{1'b1, 11'd6, 11'd4, '{24'h0F1E2D, 24'h3C4B5A, 24'h69788F, 24'h9EADBC}, 1'b0, '0},
    '{1'b0, 11'd0, 11'd0, '{24'hCBDAE9, 24'hF80716, 24'h253443, 24'h526170}, 1'b0, '0},
    '{1'b0, 11'd0, 11'd0, '{24'h01FE02, 24'hFD03FC, 24'h04FB05, 24'hFA06F9}, 1'b0, '0},
    '{1'b0, 11'd0, 11'd0, '{24'h800080, 24'h7F7F7F, 24'h008000, 24'hFF01FE}, 1'b0, '0},
    '{1'b0, 11'd0, 11'd0, '{24'h55AA55, 24'hAA55AA, 24'h33CC33, 24'hCC33CC}, 1'b0, '0},
    '{1'b0, 11'd0, 11'd0, '{24'h0A0B0C, 24'hF0E0D0, 24'h102030, 24'hC0B0A0}, 1'b0, '0},
    // odd sizes: bit zero dropped, width past the cap
    '{1'b1, 11'd1025, 11'd3, '{24'hDEADBE, 24'hEF0123, 24'h456789, 24'hABCDEF}, 1'b0, '0},
    '{1'b1, 11'd5, 11'd1024, '{24'hFEDCBA, 24'h987654, 24'h321001, 24'h234567}, 1'b0, '0}
  };

  logic      clk;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_IMAGE_WIDTH;
  logic [DIM_W-1:0]     cfg_data  = '0;

  // Predictor state
  logic [DIM_W-1:0] width_reg  = 11'd512;
  logic [DIM_W-1:0] height_reg = 11'd512;
  int               blk_col    = 0;
  int               blk_row    = 0;
  out_item_t        pending_bands [$];

  int blocks_sent    = 0;
  int results_seen   = 0;
  int mismatch_count = 0;
  int send_idle_pct  = 12;
  int recv_idle_pct  = 67;
  int cycle_count    = 0;

  haar_wavelet_2x2_rgb dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Effective dimension: even, capped at the maximum, at least two
  function automatic int effective_dim(input logic [DIM_W-1:0] r, input int cap);
    int v;
    v = int'(r) & ~1;
    if (v > (cap & ~1)) v = cap & ~1;
    if (v < 2) v = 2;
    return v;
  endfunction

  // Four band results of one block, queued in band order; counters advance
  task automatic predict_bands(input in_item_t blk, input logic typed, input band_rgb_t coefs);
    int        w, h, half_w, half_h, a, b, c, d;
    logic      frame_end;
    band_rgb_t rgb;
    pixel_t    px;
    out_item_t r;
    w      = effective_dim(width_reg, MAX_WIDTH);
    h      = effective_dim(height_reg, MAX_HEIGHT);
    half_w = w / 2;
    half_h = h / 2;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      a = int'(blk.top_left_rgb[CH_W*ch +: CH_W]);
      b = int'(blk.top_right_rgb[CH_W*ch +: CH_W]);
      c = int'(blk.bottom_left_rgb[CH_W*ch +: CH_W]);
      d = int'(blk.bottom_right_rgb[CH_W*ch +: CH_W]);
      // int division truncates toward zero
      rgb[0][CH_W*ch +: CH_W] = CH_W'((a + b + c + d) / 4);
      rgb[1][CH_W*ch +: CH_W] = CH_W'((a + b - c - d) / 4 + 128);
      rgb[2][CH_W*ch +: CH_W] = CH_W'((a - b + c - d) / 4 + 128);
      rgb[3][CH_W*ch +: CH_W] = CH_W'((a - b - c + d) / 4 + 128);
    end
    frame_end = (blk_col + 1 >= half_w) && (blk_row + 1 >= half_h);
    for (int k = 0; k < NUM_BANDS; k++) begin
      px = typed ? coefs[k] : rgb[k];
      r.band = BAND_ORDER[k];
      // quadrants: odd bands shift half a width right, bands 2 and 3 half a height down
      r.pixel_index   = IDX_W'((blk_row + (k / 2) * half_h) * w + blk_col + (k % 2) * half_w);
      r.red           = px[7:0];
      r.green         = px[15:8];
      r.blue          = px[23:16];
      r.last_of_block = (k == NUM_BANDS - 1);
      r.end_of_frame  = (k == NUM_BANDS - 1) && frame_end;
      pending_bands.push_back(r);
    end
    blk_col++;
    if (blk_col >= half_w) begin
      blk_col = 0;
      blk_row++;
      if (blk_row >= half_h) blk_row = 0;
    end
  endtask

  // One input transfer, with random gaps ahead of it
  task automatic send_block(input in_item_t blk, input logic typed, input band_rgb_t coefs);
    if (blocks_sent < 160) begin
      send_idle_pct = 12;
      recv_idle_pct = 67;
    end else if (blocks_sent < 320) begin
      send_idle_pct = 67;
      recv_idle_pct = 12;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= blk;
    do @(posedge clk); while (!in_ready);
    predict_bands(blk, typed, coefs);
    blocks_sent++;
  endtask

  // Size registers are written only once every result is out
  task automatic write_size(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
    in_valid <= 1'b0;
    while (pending_bands.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_write  <= 1'b0;
    width_reg  = w;
    height_reg = h;
  endtask

  // Mostly small images so frames complete; now and then large or extreme
  function automatic logic [DIM_W-1:0] random_size();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return DIM_W'($urandom_range(0, 12));
    if (pick < 8) return DIM_W'($urandom_range(13, 64));
    if (pick == 8) return DIM_W'($urandom_range(65, 2047));
    case ($urandom_range(0, 3))
      0: return '0;
      1: return DIM_W'(1);
      2: return DIM_W'(1024);
      default: return '1;
    endcase
  endfunction

  function automatic pixel_t random_pixel(input int kind);
    pixel_t px;
    px = pixel_t'($urandom);
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if (kind == 1) px[CH_W*ch +: CH_W] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      else if (kind == 2) px[CH_W*ch +: CH_W] = CH_W'($urandom_range(0, 7));
    end
    return px;
  endfunction

  // Full-range content, saturated corners, or tiny values near the rounding edge
  function automatic in_item_t random_block();
    in_item_t blk;
    int       pick, kind;
    pick = $urandom_range(0, 9);
    kind = (pick < 6) ? 0 : (pick < 8) ? 1 : 2;
    blk.top_left_rgb     = random_pixel(kind);
    blk.top_right_rgb    = random_pixel(kind);
    blk.bottom_left_rgb  = random_pixel(kind);
    blk.bottom_right_rgb = random_pixel(kind);
    return blk;
  endfunction

  // Receiver stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Result check against the oldest queued band
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_bands.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("result %0d with none pending: band %0d index %0d rgb %h%h%h",
                   results_seen, out_item.band, out_item.pixel_index,
                   out_item.blue, out_item.green, out_item.red);
      end else begin
        want = pending_bands.pop_front();
        if (out_item.band !== want.band || out_item.pixel_index !== want.pixel_index ||
            out_item.red !== want.red || out_item.green !== want.green ||
            out_item.blue !== want.blue || out_item.last_of_block !== want.last_of_block ||
            out_item.end_of_frame !== want.end_of_frame) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("result %0d: want band %0d idx %0d r %h g %h b %h last %b eof %b",
                     results_seen, want.band, want.pixel_index, want.red, want.green,
                     want.blue, want.last_of_block, want.end_of_frame);
            $display("result %0d: got  band %0d idx %0d r %h g %h b %h last %b eof %b",
                     results_seen, out_item.band, out_item.pixel_index, out_item.red,
                     out_item.green, out_item.blue, out_item.last_of_block,
                     out_item.end_of_frame);
          end
        end
      end
    end
  end

  // Run limit
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("haar_wavelet_2x2_rgb: mismatch");
    $finish;
  end

  initial begin : stimulus
    int left, n;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed table
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      if (DIRECTED[i].new_size) write_size(DIRECTED[i].width, DIRECTED[i].height);
      send_block(DIRECTED[i].blk, DIRECTED[i].typed, DIRECTED[i].coefs);
    end

    // Random frames; counters carry over each size change
    left = RANDOM_BLOCKS;
    while (left > 0) begin
      write_size(random_size(), random_size());
      n = $urandom_range(10, 50);
      if (n > left) n = left;
      repeat (n) send_block(random_block(), 1'b0, '0);
      left -= n;
    end

    in_valid <= 1'b0;
    while (pending_bands.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("haar_wavelet_2x2_rgb: match");
    end else begin
      $display("haar_wavelet_2x2_rgb: mismatch");
    end
    $finish;
  end

endmodule
